// File: rtl/trts_pkg.sv
// ----------------------------------------------------------------------------
// trts_pkg
// Shared types and constants for the response token scanner.
// ----------------------------------------------------------------------------
package trts_pkg;

  // Token codes.
  localparam logic [7:0] TokError      = 8'hAA;
  localparam logic [7:0] TokDone       = 8'hFD;
  localparam logic [7:0] TokDoneProc   = 8'hFE;
  localparam logic [7:0] TokDoneInProc = 8'hFF;
  localparam logic [7:0] TokInfo       = 8'hAB;
  localparam logic [7:0] TokEnvChange  = 8'hE3;

  // Status bit that marks an error in a completion token.
  localparam logic [15:0] StatusErrBit = 16'h0002;

  // Outcome codes.
  localparam logic [1:0] OutcomeOk     = 2'd0;
  localparam logic [1:0] OutcomeError  = 2'd1;
  localparam logic [1:0] OutcomeNoDone = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic [63:0] row_total;
    logic        done_seen;
    logic        error_seen;
  } out_beat_t;

endpackage

// File: rtl/trts_in_stage.sv
// ----------------------------------------------------------------------------
// trts_in_stage
// Input register: holds one byte beat until the parser takes it.
// ----------------------------------------------------------------------------
module trts_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  trts_pkg::in_beat_t in_beat_i,
  output logic              beat_valid_o,
  output trts_pkg::in_beat_t beat_o,
  input  logic              take_i
);
  import trts_pkg::*;

  logic     valid_q, valid_d;
  in_beat_t beat_q;
  logic     accept;

  // The register may refill in the same cycle that its beat is taken.
  assign in_stall_o = valid_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      beat_q <= in_beat_i;
    end
  end

  assign beat_valid_o = valid_q;
  assign beat_o       = beat_q;

endmodule

// File: rtl/trts_parser.sv
// ----------------------------------------------------------------------------
// trts_parser
// Token stream state machine: walks one byte per step and builds the outcome.
// ----------------------------------------------------------------------------
module trts_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  trts_pkg::in_beat_t beat_i,
  output trts_pkg::out_beat_t result_o
);
  import trts_pkg::*;

  typedef enum logic [3:0] {
    PhToken,
    PhErrHead,
    PhErrMsgLenLo,
    PhErrMsgLenHi,
    PhErrMsg,
    PhErrSrvLen,
    PhErrSrv,
    PhErrProcLen,
    PhErrProc,
    PhErrLine,
    PhDoneBody,
    PhSkipLenLo,
    PhSkipLenHi,
    PhSkip
  } phase_e;

  phase_e      phase_q, phase_d, ph_n;
  logic [3:0]  idx_q, idx_d, idx_n;
  logic [16:0] skip_q, skip_d, skip_n;
  logic [7:0]  len_lo_q, len_lo_d, len_lo_n;
  logic [63:0] pend_q, pend_d, pend_n;
  logic        pend_err_q, pend_err_d, pend_err_n;
  logic [63:0] latest_q, latest_d, latest_n;
  logic        done_q, done_d, done_n;
  logic        err_q, err_d, err_n;

  logic [7:0]  b;
  logic [2:0]  lane;
  logic [16:0] start_len;
  phase_e      start_skip_ph, start_next_ph;
  logic        start_skip;

  assign b    = beat_i.data_byte;
  assign lane = 3'(idx_q - 4'd4);

  always_comb begin
    ph_n       = phase_q;
    idx_n      = idx_q;
    skip_n     = skip_q;
    len_lo_n   = len_lo_q;
    pend_n     = pend_q;
    pend_err_n = pend_err_q;
    latest_n   = latest_q;
    done_n     = done_q;
    err_n      = err_q;

    start_skip    = 1'b0;
    start_len     = '0;
    start_skip_ph = PhSkip;
    start_next_ph = PhToken;

    unique case (phase_q)
      PhErrHead: begin
        idx_n = idx_q + 4'd1;
        if (idx_q == 4'd7) begin
          idx_n = '0;
          ph_n  = PhErrMsgLenLo;
        end
      end
      PhErrMsgLenLo: begin
        len_lo_n = b;
        ph_n     = PhErrMsgLenHi;
      end
      PhErrMsgLenHi: begin
        // Message length counts two-byte characters.
        start_skip    = 1'b1;
        start_len     = {b, len_lo_q, 1'b0};
        start_skip_ph = PhErrMsg;
        start_next_ph = PhErrSrvLen;
      end
      PhErrSrvLen: begin
        start_skip    = 1'b1;
        start_len     = {8'd0, b, 1'b0};
        start_skip_ph = PhErrSrv;
        start_next_ph = PhErrProcLen;
      end
      PhErrProcLen: begin
        start_skip    = 1'b1;
        start_len     = {8'd0, b, 1'b0};
        start_skip_ph = PhErrProc;
        start_next_ph = PhErrLine;
      end
      PhErrMsg, PhErrSrv, PhErrProc, PhSkip: begin
        skip_n = skip_q - 17'd1;
        if (skip_q == 17'd1) begin
          idx_n = '0;
          case (phase_q)
            PhErrMsg:  ph_n = PhErrSrvLen;
            PhErrSrv:  ph_n = PhErrProcLen;
            PhErrProc: ph_n = PhErrLine;
            default:   ph_n = PhToken;
          endcase
        end
      end
      PhErrLine: begin
        idx_n = idx_q + 4'd1;
        if (idx_q == 4'd3) begin
          idx_n = '0;
          ph_n  = PhToken;
        end
      end
      PhDoneBody: begin
        if (idx_q == 4'd0) begin
          pend_err_n = |(b & StatusErrBit[7:0]);
        end
        if (idx_q >= 4'd4 && idx_q < 4'd12) begin
          pend_n[lane*8 +: 8] = b;
        end
        idx_n = idx_q + 4'd1;
        if (idx_q >= 4'd11) begin
          latest_n = pend_n;
          done_n   = 1'b1;
          err_n    = err_q | pend_err_n;
          idx_n    = '0;
          ph_n     = PhToken;
        end
      end
      PhSkipLenLo: begin
        len_lo_n = b;
        ph_n     = PhSkipLenHi;
      end
      PhSkipLenHi: begin
        start_skip    = 1'b1;
        start_len     = {1'b0, b, len_lo_q};
        start_skip_ph = PhSkip;
        start_next_ph = PhToken;
      end
      default: begin
        idx_n = '0;
        if (b == TokError) begin
          err_n = 1'b1;
          ph_n  = PhErrHead;
        end else if (b == TokDone || b == TokDoneProc || b == TokDoneInProc) begin
          pend_n     = '0;
          pend_err_n = 1'b0;
          ph_n       = PhDoneBody;
        end else begin
          // Informational, environment change and unknown tokens share this path.
          ph_n = PhSkipLenLo;
        end
      end
    endcase

    // A zero-length section takes no bytes.
    if (start_skip) begin
      idx_n = '0;
      if (start_len == 17'd0) begin
        ph_n = start_next_ph;
      end else begin
        skip_n = start_len;
        ph_n   = start_skip_ph;
      end
    end
  end

  // The result reflects the final byte; then everything returns to reset.
  always_comb begin
    result_o.outcome    = err_n ? OutcomeError : (done_n ? OutcomeOk : OutcomeNoDone);
    result_o.row_total  = done_n ? latest_n : 64'd0;
    result_o.done_seen  = done_n;
    result_o.error_seen = err_n;
  end

  always_comb begin
    phase_d    = phase_q;
    idx_d      = idx_q;
    skip_d     = skip_q;
    len_lo_d   = len_lo_q;
    pend_d     = pend_q;
    pend_err_d = pend_err_q;
    latest_d   = latest_q;
    done_d     = done_q;
    err_d      = err_q;
    if (step_i) begin
      if (beat_i.last_byte) begin
        phase_d    = PhToken;
        idx_d      = '0;
        skip_d     = '0;
        len_lo_d   = '0;
        pend_d     = '0;
        pend_err_d = 1'b0;
        latest_d   = '0;
        done_d     = 1'b0;
        err_d      = 1'b0;
      end else begin
        phase_d    = ph_n;
        idx_d      = idx_n;
        skip_d     = skip_n;
        len_lo_d   = len_lo_n;
        pend_d     = pend_n;
        pend_err_d = pend_err_n;
        latest_d   = latest_n;
        done_d     = done_n;
        err_d      = err_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhToken;
      idx_q      <= '0;
      skip_q     <= '0;
      len_lo_q   <= '0;
      pend_q     <= '0;
      pend_err_q <= 1'b0;
      latest_q   <= '0;
      done_q     <= 1'b0;
      err_q      <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      idx_q      <= idx_d;
      skip_q     <= skip_d;
      len_lo_q   <= len_lo_d;
      pend_q     <= pend_d;
      pend_err_q <= pend_err_d;
      latest_q   <= latest_d;
      done_q     <= done_d;
      err_q      <= err_d;
    end
  end

endmodule

// File: rtl/tds_response_token_scanner.sv
// ----------------------------------------------------------------------------
// tds_response_token_scanner
// Scans a response token stream one byte per beat and reports the outcome.
// A final byte passes the input register, then the result register.
// One byte per cycle if not stalled; parse state advances once per byte.
// A full result register stalls only the final byte of the next message.
// Reset clears the parse state and both valid flags; the block starts idle.
// ----------------------------------------------------------------------------
module tds_response_token_scanner (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  trts_pkg::in_beat_t  in_beat_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output trts_pkg::out_beat_t out_beat_o
);
  import trts_pkg::*;

  logic      beat_valid;
  in_beat_t  beat;
  logic      take;
  out_beat_t result;
  logic      out_valid_q, out_valid_d;
  out_beat_t out_beat_q;
  logic      out_free;
  logic      load;

  assign out_free = !out_valid_q || !out_stall_i;
  assign take     = beat_valid && (!beat.last_byte || out_free);
  assign load     = take && beat.last_byte;

  trts_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_beat_i    (in_beat_i),
    .beat_valid_o (beat_valid),
    .beat_o       (beat),
    .take_i       (take)
  );

  trts_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (take),
    .beat_i   (beat),
    .result_o (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_beat_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

endmodule

// File: test/tds_response_token_scanner_tb.sv
// ----------------------------------------------------------------------------
// tds_response_token_scanner_tb
// Feeds response messages byte by byte into the token scanner and checks
// every result it gives. A short table of hand-built messages comes first.
// Random messages built from well-formed tokens follow, mixed with noise and
// cut-short messages. An internal scanner model predicts each result of the
// random messages. Both sides idle at random, and once the receiver holds
// off long enough to back the block up.
// ----------------------------------------------------------------------------
module tds_response_token_scanner_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import trts_pkg::*;

  typedef enum logic [3:0] {
    PhToken, PhErrHead, PhErrMsgLenLo, PhErrMsgLenHi, PhErrMsg, PhErrSrvLen,
    PhErrSrv, PhErrProcLen, PhErrProc, PhErrLine, PhDoneBody, PhSkipLenLo,
    PhSkipLenHi, PhSkip
  } scan_phase_e;

  typedef struct {
    logic [7:0] data;
    bit         last;
    bit         typed;
    out_beat_t  want;
  } stim_row_t;

  localparam out_beat_t ResNoDone      = '{OutcomeNoDone, 64'd0, 1'b0, 1'b0};
  localparam out_beat_t ResCutError    = '{OutcomeError, 64'd0, 1'b0, 1'b1};
  localparam out_beat_t ResErrMaxCount = '{OutcomeError, '1, 1'b1, 1'b1};

  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned RandomBytes   = 2000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_beat;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_beat;

  out_beat_t   expected_results[$];
  logic [7:0]  msg_bytes[$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_cnt = 0;

  // Scanner model state.
  scan_phase_e scan_phase;
  logic [3:0]  scan_idx;
  logic [16:0] skip_left;
  logic [7:0]  len_lo;
  logic [63:0] pend_count;
  logic        pend_err;
  logic [63:0] row_latest;
  logic        done_flag;
  logic        err_flag;

  // Hand-built messages: cut tokens, zero and short skips, and a completion
  // token with the error status and the largest row count.
  stim_row_t directed_rows [24] = '{
    '{8'hFD, 1'b1, 1'b1, ResNoDone},
    '{8'hAA, 1'b1, 1'b1, ResCutError},
    '{8'hFE, 1'b1, 1'b1, ResNoDone},
    '{8'h00, 1'b1, 1'b1, ResNoDone},
    '{8'hAB, 1'b0, 1'b0, ResNoDone},
    '{8'h00, 1'b0, 1'b0, ResNoDone},
    '{8'h00, 1'b1, 1'b1, ResNoDone},
    '{8'hE3, 1'b0, 1'b0, ResNoDone},
    '{8'h01, 1'b0, 1'b0, ResNoDone},
    '{8'h00, 1'b0, 1'b0, ResNoDone},
    '{8'h55, 1'b1, 1'b1, ResNoDone},
    '{8'hFF, 1'b0, 1'b0, ResNoDone},
    '{8'h02, 1'b0, 1'b0, ResNoDone},
    '{8'h00, 1'b0, 1'b0, ResNoDone},
    '{8'h00, 1'b0, 1'b0, ResNoDone},
    '{8'h00, 1'b0, 1'b0, ResNoDone},
    '{8'hFF, 1'b0, 1'b0, ResNoDone},
    '{8'hFF, 1'b0, 1'b0, ResNoDone},
    '{8'hFF, 1'b0, 1'b0, ResNoDone},
    '{8'hFF, 1'b0, 1'b0, ResNoDone},
    '{8'hFF, 1'b0, 1'b0, ResNoDone},
    '{8'hFF, 1'b0, 1'b0, ResNoDone},
    '{8'hFF, 1'b0, 1'b0, ResNoDone},
    '{8'hFF, 1'b1, 1'b1, ResErrMaxCount}
  };

  tds_response_token_scanner u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_beat_o  (out_beat)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #(5_000_000);
    $display("tb: failure");
    $finish;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  // Neither side idles inside this window.
  function automatic bit no_idle();
    return cycle_cnt >= 1200 && cycle_cnt < 2200;
  endfunction

  function automatic void add_byte(logic [7:0] v);
    msg_bytes.insert(msg_bytes.size(), v);
  endfunction

  function automatic void scan_reset();
    scan_phase = PhToken;
    scan_idx   = '0;
    skip_left  = '0;
    len_lo     = '0;
    pend_count = '0;
    pend_err   = 1'b0;
    row_latest = '0;
    done_flag  = 1'b0;
    err_flag   = 1'b0;
  endfunction

  function automatic void open_skip(logic [16:0] n, scan_phase_e skip_ph,
                                    scan_phase_e next_ph);
    if (n == '0) begin
      scan_phase = next_ph;
    end else begin
      skip_left  = n;
      scan_phase = skip_ph;
    end
    scan_idx = '0;
  endfunction

  function automatic void skip_step(scan_phase_e next_ph);
    if (skip_left != '0) skip_left = skip_left - 1'b1;
    if (skip_left == '0) begin
      scan_phase = next_ph;
      scan_idx   = '0;
    end
  endfunction

  // Advances the model by one byte; returns 1 with the result on a final byte.
  function automatic bit scan_byte(in_beat_t b, output out_beat_t res);
    logic [7:0] d;
    d   = b.data_byte;
    res = '0;
    case (scan_phase)
      PhErrHead: begin
        scan_idx = scan_idx + 1'b1;
        if (scan_idx >= 4'd8) begin
          scan_idx   = '0;
          scan_phase = PhErrMsgLenLo;
        end
      end
      PhErrMsgLenLo: begin
        len_lo     = d;
        scan_phase = PhErrMsgLenHi;
      end
      PhErrMsgLenHi: open_skip({d, len_lo, 1'b0}, PhErrMsg, PhErrSrvLen);
      PhErrMsg:      skip_step(PhErrSrvLen);
      PhErrSrvLen:   open_skip({8'h00, d, 1'b0}, PhErrSrv, PhErrProcLen);
      PhErrSrv:      skip_step(PhErrProcLen);
      PhErrProcLen:  open_skip({8'h00, d, 1'b0}, PhErrProc, PhErrLine);
      PhErrProc:     skip_step(PhErrLine);
      PhErrLine: begin
        scan_idx = scan_idx + 1'b1;
        if (scan_idx >= 4'd4) begin
          scan_idx   = '0;
          scan_phase = PhToken;
        end
      end
      PhDoneBody: begin
        if (scan_idx == 4'd0) pend_err = |(d & StatusErrBit[7:0]);
        if (scan_idx >= 4'd4 && scan_idx < 4'd12) begin
          pend_count = pend_count | (64'(d) << ((int'(scan_idx) - 4) * 8));
        end
        scan_idx = scan_idx + 1'b1;
        if (scan_idx >= 4'd12) begin
          row_latest = pend_count;
          done_flag  = 1'b1;
          if (pend_err) err_flag = 1'b1;
          scan_idx   = '0;
          scan_phase = PhToken;
        end
      end
      PhSkipLenLo: begin
        len_lo     = d;
        scan_phase = PhSkipLenHi;
      end
      PhSkipLenHi: open_skip({1'b0, d, len_lo}, PhSkip, PhToken);
      PhSkip:      skip_step(PhToken);
      default: begin
        scan_idx = '0;
        if (d == TokError) begin
          err_flag   = 1'b1;
          scan_phase = PhErrHead;
        end else if (d == TokDone || d == TokDoneProc || d == TokDoneInProc) begin
          pend_count = '0;
          pend_err   = 1'b0;
          scan_phase = PhDoneBody;
        end else begin
          scan_phase = PhSkipLenLo;
        end
      end
    endcase
    if (!b.last_byte) return 1'b0;
    res.outcome    = err_flag ? OutcomeError : (done_flag ? OutcomeOk : OutcomeNoDone);
    res.row_total  = done_flag ? row_latest : 64'd0;
    res.done_seen  = done_flag;
    res.error_seen = err_flag;
    scan_reset();
    return 1'b1;
  endfunction

  // Builds one random message into msg_bytes. Most are sequences of
  // well-formed tokens; some are noise, some end in the middle of a token.
  task automatic build_message();
    int unsigned n_tok;
    int unsigned kind;
    int unsigned n;
    bit          cut_open;
    logic [7:0]  stat_lo;
    logic [15:0] len;
    msg_bytes.delete();
    if ($urandom_range(9) == 0) begin
      n = $urandom_range(1, 8);
      repeat (n) add_byte(8'($urandom));
      return;
    end
    n_tok    = $urandom_range(1, 4);
    cut_open = 1'b0;
    for (int t = 0; t < n_tok && !cut_open; t++) begin
      kind = $urandom_range(9);
      if (kind < 4) begin
        case ($urandom_range(2))
          0:       add_byte(TokDone);
          1:       add_byte(TokDoneProc);
          default: add_byte(TokDoneInProc);
        endcase
        stat_lo = 8'($urandom);
        if ($urandom_range(3) != 0) stat_lo = stat_lo & ~StatusErrBit[7:0];
        add_byte(stat_lo);
        repeat (3) add_byte(8'($urandom));
        case ($urandom_range(3))
          0:       repeat (8) add_byte(8'h00);
          1:       repeat (8) add_byte(8'hFF);
          default: repeat (8) add_byte(8'($urandom));
        endcase
      end else if (kind < 6) begin
        add_byte(TokError);
        repeat (8) add_byte(8'($urandom));
        if ($urandom_range(15) == 0) begin
          // Huge message length: the message ends inside the text.
          len = 16'($urandom);
          add_byte(len[7:0]);
          add_byte(len[15:8]);
          repeat ($urandom_range(0, 20)) add_byte(8'($urandom));
          cut_open = 1'b1;
        end else begin
          n = $urandom_range(0, 4);
          add_byte(8'(n));
          add_byte(8'h00);
          repeat (2 * n) add_byte(8'($urandom));
          repeat (2) begin
            n = $urandom_range(0, 3);
            add_byte(8'(n));
            repeat (2 * n) add_byte(8'($urandom));
          end
          repeat (4) add_byte(8'($urandom));
        end
      end else begin
        case ($urandom_range(2))
          0:       add_byte(TokInfo);
          1:       add_byte(TokEnvChange);
          default: add_byte(8'($urandom));
        endcase
        if ($urandom_range(15) == 0) begin
          len = 16'($urandom);
          add_byte(len[7:0]);
          add_byte(len[15:8]);
          repeat ($urandom_range(0, 20)) add_byte(8'($urandom));
          cut_open = 1'b1;
        end else begin
          n = $urandom_range(0, 6);
          add_byte(8'(n));
          add_byte(8'h00);
          repeat (n) add_byte(8'($urandom));
        end
      end
    end
    if (!cut_open && $urandom_range(4) == 0) begin
      n = $urandom_range(1, msg_bytes.size());
      while (msg_bytes.size() > n) void'(msg_bytes.pop_back());
    end
  endtask

  // Offers one beat, waits until it is taken, then updates the model.
  task automatic send_beat(in_beat_t b, bit typed, out_beat_t want);
    out_beat_t predicted;
    @(negedge clk);
    while (!no_idle() && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= b;
    do @(posedge clk); while (in_stall);
    if (scan_byte(b, predicted)) begin
      expected_results.insert(expected_results.size(), typed ? want : predicted);
    end
  endtask

  function automatic void flag_error(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  initial begin
    in_beat_t    beat;
    int unsigned n_sent;
    in_valid = 1'b0;
    in_beat  = '0;
    scan_reset();
    wait (rst_n === 1'b1);
    foreach (directed_rows[i]) begin
      beat.data_byte = directed_rows[i].data;
      beat.last_byte = directed_rows[i].last;
      send_beat(beat, directed_rows[i].typed, directed_rows[i].want);
    end
    n_sent = 0;
    while (n_sent < RandomBytes) begin
      build_message();
      foreach (msg_bytes[i]) begin
        beat.data_byte = msg_bytes[i];
        beat.last_byte = (i == msg_bytes.size() - 1);
        send_beat(beat, 1'b0, '0);
        n_sent++;
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off that backs up the block.
  initial begin
    bit held;
    held      = 1'b0;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!held && results_seen >= 12) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HoldOffCycles) @(negedge clk);
      end
      out_stall <= !no_idle() && ($urandom_range(99) < 19);
    end
  end

  always @(posedge clk) begin : check_results
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        flag_error($sformatf("unexpected result: outcome=%0d rows=%h done=%0b err=%0b",
                             out_beat.outcome, out_beat.row_total,
                             out_beat.done_seen, out_beat.error_seen));
      end else begin
        want = expected_results.pop_front();
        if (out_beat.outcome !== want.outcome || out_beat.row_total !== want.row_total ||
            out_beat.done_seen !== want.done_seen ||
            out_beat.error_seen !== want.error_seen) begin
          flag_error($sformatf({"result mismatch: expected outcome=%0d rows=%h done=%0b ",
                                "err=%0b, got outcome=%0d rows=%h done=%0b err=%0b"},
                               want.outcome, want.row_total, want.done_seen,
                               want.error_seen, out_beat.outcome, out_beat.row_total,
                               out_beat.done_seen, out_beat.error_seen));
        end
      end
    end
  end

endmodule
